// ===== sv/wcf_pkg.sv =====
`default_nettype none
package wcf_pkg;

   // field widths
   localparam int DIR_W    = 4;
   localparam int BYTE_W   = 8;
   localparam int CRC_W    = 16;
   localparam int IDX_W    = 4;
   localparam int CSR_IX_W = 8;

   // frame layout, transmit order
   localparam logic [IDX_W-1:0] POS_SOF     = 4'd0;
   localparam logic [IDX_W-1:0] POS_CMD     = 4'd1;
   localparam logic [IDX_W-1:0] POS_LEFT    = 4'd2;
   localparam logic [IDX_W-1:0] POS_PAD_L   = 4'd3;
   localparam logic [IDX_W-1:0] POS_RIGHT   = 4'd4;
   localparam logic [IDX_W-1:0] POS_PAD_R   = 4'd5;
   localparam logic [IDX_W-1:0] POS_FLAG    = 4'd6;
   localparam logic [IDX_W-1:0] POS_CRC_LO  = 4'd7;
   localparam logic [IDX_W-1:0] POS_CRC_HI  = 4'd8;

   localparam logic [BYTE_W-1:0] SOF_BYTE   = 8'hFF;
   localparam logic [BYTE_W-1:0] CMD_BYTE   = 8'h07;
   localparam logic [BYTE_W-1:0] PAD_BYTE   = 8'h00;

   // direction codes
   localparam logic [DIR_W-1:0] DIR_FWD        = 4'd0;
   localparam logic [DIR_W-1:0] DIR_FWD_LEFT   = 4'd1;
   localparam logic [DIR_W-1:0] DIR_FWD_RIGHT  = 4'd2;
   localparam logic [DIR_W-1:0] DIR_RIGHT      = 4'd3;
   localparam logic [DIR_W-1:0] DIR_LEFT       = 4'd4;
   localparam logic [DIR_W-1:0] DIR_BACK       = 4'd5;
   localparam logic [DIR_W-1:0] DIR_BACK_LEFT  = 4'd6;
   localparam logic [DIR_W-1:0] DIR_BACK_RIGHT = 4'd7;

   // flag byte values
   localparam logic [BYTE_W-1:0] FLAG_FWD   = 8'b0101_0000;
   localparam logic [BYTE_W-1:0] FLAG_RIGHT = 8'b0100_0000;
   localparam logic [BYTE_W-1:0] FLAG_LEFT  = 8'b0001_0000;
   localparam logic [BYTE_W-1:0] FLAG_BACK  = 8'b0000_0000;

   // register indexes and reset values
   localparam logic [CSR_IX_W-1:0] CSR_TURN_RED       = 8'd0;
   localparam logic [CSR_IX_W-1:0] CSR_BACK_RIGHT_RED = 8'd1;
   localparam logic [BYTE_W-1:0]   TURN_RED_RESET       = 8'd70;
   localparam logic [BYTE_W-1:0]   BACK_RIGHT_RED_RESET = 8'd130;

   // CRC-16/MODBUS
   localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;
   localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;

   // one byte into the reflected CRC, bit at a time
   function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] data);
      logic [CRC_W-1:0] c;
      c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, data};
      for (int b = 0; b < BYTE_W; b++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   // speed less the reduction, clamped at zero
   function automatic logic [BYTE_W-1:0] reduce(input logic [BYTE_W-1:0] speed,
                                                input logic [BYTE_W-1:0] amount);
      return (speed > amount) ? (speed - amount) : '0;
   endfunction

endpackage
`default_nettype wire

// ===== sv/wheel_command_frame_crc16.sv =====
// Wheel command frame builder.
// req channel: one drive command per transfer, tdata = direction, speed.
// rsp channel: nine byte transfers per command, 0xFF, 0x07, left speed,
//   0x00, right speed, 0x00, flag byte, CRC low, CRC high; tlast marks the
//   CRC high byte. The CRC is CRC-16/MODBUS over bytes 1 to 6.
// csr channel: register writes (index 0 turn reduction, 1 backward-right
//   reduction); always ready, write only while no frame is in flight.
// When the serialiser is free, a command goes first into the holding
//   register and from there into the serialiser, which raises rsp_tvalid.
// The byte-wide serialiser emits one frame byte a cycle and folds one byte
//   a cycle into the running CRC while rsp_tready is high. One command
//   waits in a holding register while a frame is being sent, so the next
//   frame follows the last byte with no gap.
// Reset: no frame in flight, flag byte 0, reductions 70 and 130.
// A stalled rsp side holds the current byte; once the holding register is
//   full req_tready drops until the serialiser takes the command.
`default_nettype none
module wheel_command_frame_crc16 (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [3:0] direction, [11:4] speed, [15:12] zero
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [7:0] frame_byte
   output logic             rsp_tlast,   // last_byte
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_index,
   input  wire logic [7:0]  csr_data
);

   localparam int BW = wcf_pkg::BYTE_W;

   logic [BW-1:0] turn_red_ff, back_red_ff;
   logic [BW-1:0] flag_ff, flag_in;
   logic [BW-1:0] left_in, right_in;

   logic          pend_valid_ff;
   logic [BW-1:0] pend_left_ff, pend_right_ff, pend_flag_ff;

   logic          active_ff;
   logic [wcf_pkg::IDX_W-1:0] idx_ff;
   logic [BW-1:0] left_ff, right_ff, fbyte_ff;
   logic [wcf_pkg::CRC_W-1:0] crc_ff;

   logic [wcf_pkg::DIR_W-1:0] dir;
   logic [BW-1:0] speed;
   logic          req_xfer, rsp_xfer, last_beat, load;
   logic [BW-1:0] cur_byte;

   assign dir   = req_tdata[wcf_pkg::DIR_W-1:0];
   assign speed = req_tdata[wcf_pkg::DIR_W +: BW];

   // configuration registers
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         turn_red_ff <= wcf_pkg::TURN_RED_RESET;
         back_red_ff <= wcf_pkg::BACK_RIGHT_RED_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            wcf_pkg::CSR_TURN_RED:       turn_red_ff <= csr_data;
            wcf_pkg::CSR_BACK_RIGHT_RED: back_red_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // wheel speeds and flag byte from the command
   always_comb begin
      left_in  = speed;
      right_in = speed;
      flag_in  = flag_ff;
      case (dir)
         wcf_pkg::DIR_FWD: flag_in = wcf_pkg::FLAG_FWD;
         wcf_pkg::DIR_FWD_LEFT: begin
            left_in = wcf_pkg::reduce(speed, turn_red_ff);
            flag_in = wcf_pkg::FLAG_FWD;
         end
         wcf_pkg::DIR_FWD_RIGHT: begin
            right_in = wcf_pkg::reduce(speed, turn_red_ff);
            flag_in  = wcf_pkg::FLAG_FWD;
         end
         wcf_pkg::DIR_RIGHT: flag_in = wcf_pkg::FLAG_RIGHT;
         wcf_pkg::DIR_LEFT:  flag_in = wcf_pkg::FLAG_LEFT;
         wcf_pkg::DIR_BACK:  flag_in = wcf_pkg::FLAG_BACK;
         wcf_pkg::DIR_BACK_LEFT: begin
            left_in = wcf_pkg::reduce(speed, turn_red_ff);
            flag_in = wcf_pkg::FLAG_BACK;
         end
         wcf_pkg::DIR_BACK_RIGHT: begin
            right_in = wcf_pkg::reduce(speed, back_red_ff);
            flag_in  = wcf_pkg::FLAG_BACK;
         end
         default: begin
            // no direction: stop, keep previous flag
            left_in  = '0;
            right_in = '0;
         end
      endcase
   end

   // handshakes
   assign rsp_xfer   = rsp_tvalid && rsp_tready;
   assign last_beat  = (idx_ff == wcf_pkg::POS_CRC_HI);
   assign load       = pend_valid_ff && (!active_ff || (rsp_xfer && last_beat));
   assign req_tready = !pend_valid_ff || load;
   assign req_xfer   = req_tvalid && req_tready;

   // holding register for the next command
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         flag_ff       <= '0;
      end else begin
         if (req_xfer) begin
            pend_valid_ff <= 1'b1;
            flag_ff       <= flag_in;
         end else if (load) begin
            pend_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         pend_left_ff  <= left_in;
         pend_right_ff <= right_in;
         pend_flag_ff  <= flag_in;
      end
   end

   // current frame byte
   always_comb begin
      case (idx_ff)
         wcf_pkg::POS_SOF:    cur_byte = wcf_pkg::SOF_BYTE;
         wcf_pkg::POS_CMD:    cur_byte = wcf_pkg::CMD_BYTE;
         wcf_pkg::POS_LEFT:   cur_byte = left_ff;
         wcf_pkg::POS_RIGHT:  cur_byte = right_ff;
         wcf_pkg::POS_FLAG:   cur_byte = fbyte_ff;
         wcf_pkg::POS_CRC_LO: cur_byte = crc_ff[BW-1:0];
         wcf_pkg::POS_CRC_HI: cur_byte = crc_ff[wcf_pkg::CRC_W-1:BW];
         default:             cur_byte = wcf_pkg::PAD_BYTE;
      endcase
   end

   assign rsp_tvalid = active_ff;
   assign rsp_tdata  = cur_byte;
   assign rsp_tlast  = last_beat;

   // serialiser control
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         idx_ff    <= wcf_pkg::POS_SOF;
      end else if (load) begin
         active_ff <= 1'b1;
         idx_ff    <= wcf_pkg::POS_SOF;
      end else if (rsp_xfer) begin
         if (last_beat) begin
            active_ff <= 1'b0;
         end
         idx_ff <= idx_ff + wcf_pkg::IDX_W'(1);
      end
   end

   // frame payload and running CRC over bytes 1 to 6
   always_ff @(posedge clock) begin
      if (load) begin
         left_ff  <= pend_left_ff;
         right_ff <= pend_right_ff;
         fbyte_ff <= pend_flag_ff;
         crc_ff   <= wcf_pkg::CRC_INIT;
      end else if (rsp_xfer &&
                   (idx_ff inside {[wcf_pkg::POS_CMD:wcf_pkg::POS_FLAG]})) begin
         crc_ff <= wcf_pkg::crc16_byte(crc_ff, cur_byte);
      end
   end

endmodule
`default_nettype wire

// ===== sv/wheel_command_frame_crc16_checker.sv =====
`default_nettype none
module wheel_command_frame_crc16_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [7:0]  rsp_tdata,
   input wire logic        rsp_tlast
);

   logic [wcf_pkg::IDX_W-1:0] beat_ff;

   // position of the next rsp transfer within its frame
   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff <= wcf_pkg::POS_SOF;
      end else if (rsp_tvalid && rsp_tready) begin
         beat_ff <= rsp_tlast ? wcf_pkg::POS_SOF : beat_ff + wcf_pkg::IDX_W'(1);
      end
   end

   // tlast exactly on the ninth byte
   a_last_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (beat_ff == wcf_pkg::POS_CRC_HI)))
      else $error("tlast out of place in frame");

   // every frame opens with the start byte and the command byte
   a_sof: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && beat_ff == wcf_pkg::POS_SOF) |-> rsp_tdata == wcf_pkg::SOF_BYTE)
      else $error("frame does not start with 0xFF");

   a_cmd: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && beat_ff == wcf_pkg::POS_CMD) |-> rsp_tdata == wcf_pkg::CMD_BYTE)
      else $error("second frame byte is not 0x07");

   // nothing offered right after reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

   // stalled byte holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp byte changed while stalled");

endmodule

bind wheel_command_frame_crc16 wheel_command_frame_crc16_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire

// ===== tb/sv/wheel_command_frame_crc16_test.sv =====
module wheel_command_frame_crc16_test;
   import wcf_pkg::*;

   // direction codes that carry no movement
   localparam logic [DIR_W-1:0] DIR_NONE       = 4'd8;
   localparam logic [DIR_W-1:0] DIR_UNKNOWN_LO = 4'd9;
   localparam logic [DIR_W-1:0] DIR_UNKNOWN_HI = 4'd15;
   // an index that selects no register
   localparam logic [CSR_IX_W-1:0] CSR_NO_REG  = 8'hFE;
   localparam int FRAME_LEN   = 9;
   localparam int SETTLE      = 16;
   localparam int TIMEOUT     = 8_000_000;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [DIR_W-1:0]  dir;
      logic [BYTE_W-1:0] speed;
   } drive_cmd_type;

   typedef struct packed {
      logic [BYTE_W-1:0] octet;
      logic              is_last;
   } frame_octet_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   wire logic         req_tready;
   logic [15:0]       req_tdata = '0;
   wire logic         rsp_tvalid;
   logic              rsp_tready = 1'b0;
   wire logic [7:0]   rsp_tdata;
   wire logic         rsp_tlast;
   logic              csr_valid = 1'b0;
   wire logic         csr_ready;
   logic [7:0]        csr_index = '0;
   logic [7:0]        csr_data = '0;

   drive_cmd_type     pending_cmds[$];
   frame_octet_type   due_octets[$];

   // shadow of the block's registers and flag state
   logic [BYTE_W-1:0] turn_red;
   logic [BYTE_W-1:0] back_red;
   logic [BYTE_W-1:0] flag_state;

   int                mismatches = 0;
   int                send_gap = 0;
   int                stall_left = 0;
   bit                idle_on = 1'b1;

   wheel_command_frame_crc16 i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // mostly short gaps, now and then a long one; none while idling is off
   function automatic int draw_gap();
      int r;
      if (!idle_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // reflected CRC, one data bit per step
   function automatic logic [CRC_W-1:0] crc_fold(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] data);
      logic [CRC_W-1:0] acc;
      logic             fb;
      acc = crc;
      for (int i = 0; i < BYTE_W; i++) begin
         fb  = acc[0] ^ data[i];
         acc = acc >> 1;
         if (fb) acc = acc ^ 16'hA001;
      end
      return acc;
   endfunction

   function automatic logic [BYTE_W-1:0] clamp_sub(input logic [BYTE_W-1:0] speed,
                                                   input logic [BYTE_W-1:0] amount);
      return (speed > amount) ? speed - amount : 8'd0;
   endfunction

   // work out the nine frame bytes of one command
   task automatic predict_frame(input logic [DIR_W-1:0] dir, input logic [BYTE_W-1:0] speed);
      logic [BYTE_W-1:0] left_spd;
      logic [BYTE_W-1:0] right_spd;
      logic [BYTE_W-1:0] frame [0:FRAME_LEN-1];
      logic [CRC_W-1:0]  crc;
      frame_octet_type   fo;
      left_spd  = speed;
      right_spd = speed;
      case (dir)
         DIR_FWD: flag_state = FLAG_FWD;
         DIR_FWD_LEFT: begin
            left_spd   = clamp_sub(speed, turn_red);
            flag_state = FLAG_FWD;
         end
         DIR_FWD_RIGHT: begin
            right_spd  = clamp_sub(speed, turn_red);
            flag_state = FLAG_FWD;
         end
         DIR_RIGHT: flag_state = FLAG_RIGHT;
         DIR_LEFT: flag_state = FLAG_LEFT;
         DIR_BACK: flag_state = FLAG_BACK;
         DIR_BACK_LEFT: begin
            left_spd   = clamp_sub(speed, turn_red);
            flag_state = FLAG_BACK;
         end
         DIR_BACK_RIGHT: begin
            right_spd  = clamp_sub(speed, back_red);
            flag_state = FLAG_BACK;
         end
         default: begin
            // no movement: both wheels stop, flag byte kept
            left_spd  = 8'd0;
            right_spd = 8'd0;
         end
      endcase
      frame[0] = 8'hFF;
      frame[1] = 8'h07;
      frame[2] = left_spd;
      frame[3] = 8'h00;
      frame[4] = right_spd;
      frame[5] = 8'h00;
      frame[6] = flag_state;
      crc = 16'hFFFF;
      for (int k = 1; k <= 6; k++) crc = crc_fold(crc, frame[k]);
      frame[7] = crc[7:0];
      frame[8] = crc[15:8];
      for (int k = 0; k < FRAME_LEN; k++) begin
         fo.octet   = frame[k];
         fo.is_last = (k == FRAME_LEN - 1);
         due_octets.push_back(fo);
      end
   endtask

   task automatic note_mismatch(input string what, input logic [7:0] want,
                                input logic [7:0] got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("%0t mismatch: %s expected %h got %h", $time, what, want, got);
   endtask

   // command driver: one transfer per queued command, random gaps after each
   always @(posedge clock) begin : driver
      drive_cmd_type c;
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else if (!req_tvalid || req_tready) begin
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (pending_cmds.size() > 0) begin
            c = pending_cmds.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {4'b0000, c.speed, c.dir};
            send_gap = draw_gap();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // frame receiver with random stalls
   always @(posedge clock) begin : receiver
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         stall_left = draw_gap();
      end
   end

   // monitor: register writes, command transfers and frame bytes
   always @(posedge clock) begin : monitor
      frame_octet_type due;
      if (reset) begin
         turn_red   = TURN_RED_RESET;
         back_red   = BACK_RIGHT_RED_RESET;
         flag_state = 8'h00;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_TURN_RED) turn_red = csr_data;
            else if (csr_index == CSR_BACK_RIGHT_RED) back_red = csr_data;
         end
         if (req_tvalid && req_tready) predict_frame(req_tdata[3:0], req_tdata[11:4]);
         if (rsp_tvalid && rsp_tready) begin
            if (due_octets.size() == 0) begin
               note_mismatch("frame byte with none due", 8'h00, rsp_tdata);
            end else begin
               due = due_octets.pop_front();
               if (rsp_tdata !== due.octet) note_mismatch("frame byte", due.octet, rsp_tdata);
               if (rsp_tlast !== due.is_last)
                  note_mismatch("tlast", {7'b0, due.is_last}, {7'b0, rsp_tlast});
            end
         end
      end
   end

   task automatic push_cmd(input logic [DIR_W-1:0] dir, input logic [BYTE_W-1:0] speed);
      drive_cmd_type c;
      c.dir   = dir;
      c.speed = speed;
      pending_cmds.push_back(c);
   endtask

   // mostly real moves, speeds often close to a reduction boundary
   function automatic drive_cmd_type draw_cmd();
      drive_cmd_type c;
      int            r;
      int            s;
      r = $urandom_range(0, 99);
      if (r < 80) c.dir = DIR_W'($urandom_range(DIR_FWD, DIR_BACK_RIGHT));
      else if (r < 90) c.dir = DIR_NONE;
      else c.dir = DIR_W'($urandom_range(DIR_UNKNOWN_LO, DIR_UNKNOWN_HI));
      r = $urandom_range(0, 99);
      if (r < 60) s = $urandom_range(0, 255);
      else if (r < 75) s = int'(turn_red) + int'($urandom_range(0, 4)) - 2;
      else if (r < 90) s = int'(back_red) + int'($urandom_range(0, 4)) - 2;
      else s = $urandom_range(0, 1) ? 255 : 0;
      c.speed = s[7:0];
      return c;
   endfunction

   // wait for every frame to come back, then a little longer
   task automatic wait_idle();
      while (pending_cmds.size() != 0 || req_tvalid || due_octets.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic run_phase(input int count);
      repeat (count) pending_cmds.push_back(draw_cmd());
      wait_idle();
   endtask

   task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin : stimulus
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: flag kept from reset, clamp edges, every direction
      push_cmd(DIR_NONE, 8'd0);
      push_cmd(DIR_FWD, 8'd0);
      push_cmd(DIR_FWD, 8'd255);
      push_cmd(DIR_FWD_LEFT, 8'd70);
      push_cmd(DIR_FWD_LEFT, 8'd71);
      push_cmd(DIR_FWD_LEFT, 8'd69);
      push_cmd(DIR_FWD_LEFT, 8'd255);
      push_cmd(DIR_FWD_LEFT, 8'd0);
      push_cmd(DIR_FWD_RIGHT, 8'd70);
      push_cmd(DIR_FWD_RIGHT, 8'd71);
      push_cmd(DIR_FWD_RIGHT, 8'd255);
      push_cmd(DIR_RIGHT, 8'd255);
      push_cmd(DIR_RIGHT, 8'd0);
      push_cmd(DIR_NONE, 8'd200);
      push_cmd(DIR_LEFT, 8'd128);
      push_cmd(DIR_UNKNOWN_HI, 8'd77);
      push_cmd(DIR_BACK, 8'd255);
      push_cmd(DIR_BACK_LEFT, 8'd70);
      push_cmd(DIR_BACK_LEFT, 8'd71);
      push_cmd(DIR_BACK_LEFT, 8'd0);
      push_cmd(DIR_BACK_RIGHT, 8'd130);
      push_cmd(DIR_BACK_RIGHT, 8'd131);
      push_cmd(DIR_BACK_RIGHT, 8'd129);
      push_cmd(DIR_BACK_RIGHT, 8'd255);
      push_cmd(DIR_UNKNOWN_LO, 8'd1);
      wait_idle();

      // no reduction at all
      write_reg(CSR_TURN_RED, 8'd0);
      write_reg(CSR_BACK_RIGHT_RED, 8'd0);
      run_phase(60);

      // largest reductions, back to back with no idling
      write_reg(CSR_TURN_RED, 8'd255);
      write_reg(CSR_BACK_RIGHT_RED, 8'd255);
      idle_on = 1'b0;
      run_phase(60);
      idle_on = 1'b1;

      // random settings; a write to an unused index must change nothing
      write_reg(CSR_TURN_RED, 8'($urandom_range(0, 255)));
      write_reg(CSR_BACK_RIGHT_RED, 8'($urandom_range(0, 255)));
      write_reg(CSR_NO_REG, 8'h33);
      run_phase(100);

      write_reg(CSR_TURN_RED, 8'd1);
      write_reg(CSR_BACK_RIGHT_RED, 8'd254);
      run_phase(80);

      write_reg(CSR_TURN_RED, TURN_RED_RESET);
      write_reg(CSR_BACK_RIGHT_RED, BACK_RIGHT_RED_RESET);
      run_phase(45);

      if (mismatches == 0 && due_octets.size() == 0) begin
         $display("wheel_command_frame_crc16_test passed");
      end else begin
         $display("wheel_command_frame_crc16_test failed");
      end
      $finish;
   end

   initial begin : watchdog
      #TIMEOUT;
      $display("wheel_command_frame_crc16_test failed");
      $finish;
   end

endmodule
